// ===== rtl/core/alarm_qualify_priority_engine_top_assert.svh =====
// Assertion macros used by the alarm qualify engine datapath.
`ifndef ALARM_QUALIFY_PRIORITY_ENGINE_TOP_ASSERT_SVH
`define ALARM_QUALIFY_PRIORITY_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define AQPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define AQPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/aqpe_pkg.sv =====
// Types, constants and alarm ROM for the alarm qualify engine.
package aqpe_pkg;

  localparam int unsigned NUM_ALARMS = 13;
  localparam int unsigned COND_W     = 13;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned SLOTS      = 16;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned GUARD_W    = 6;

  localparam logic [STEP_W-1:0]  STEP_RESET     = 10'd50;
  localparam logic [IDX_W-1:0]   IDX_NONE       = 4'd15;
  localparam logic [IDX_W-1:0]   SIGNAL_ONLY    = 4'd12;
  localparam logic [TIMER_W-1:0] T_LONG         = 16'd2000;
  localparam logic [TIMER_W-1:0] T_SHORT        = 16'd1000;
  localparam logic [TIMER_W-1:0] T_BLOOD        = 16'd5000;

  typedef enum logic [2:0] {
    G_ANY  = 3'd0,
    G_STOP = 3'd1,
    G_ART  = 3'd2,
    G_VEN  = 3'd3,
    G_FILT = 3'd4,
    G_WAIT = 3'd5,
    G_NONE = 3'd6
  } guard_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SCAN    = 3'd1,
    S_SERVICE = 3'd2,
    S_SEQ     = 3'd3,
    S_EMIT    = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic service;
    logic announce;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic busy;
    logic out_free;
  } status_t;

  function automatic logic [TIMER_W-1:0] entry_ms(input logic [IDX_W-1:0] k);
    logic [TIMER_W-1:0] t;
    unique case (k)
      4'd2, 4'd3, 4'd4: t = T_SHORT;
      4'd5:             t = T_BLOOD;
      4'd0, 4'd1, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: t = T_LONG;
      default:          t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [TIMER_W-1:0] exit_ms(input logic [IDX_W-1:0] k);
    logic [TIMER_W-1:0] t;
    unique case (k)
      4'd2, 4'd3, 4'd4: t = T_SHORT;
      4'd0, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: t = T_LONG;
      default:          t = '0;
    endcase
    return t;
  endfunction

  function automatic guard_e action_of(input logic [IDX_W-1:0] k);
    guard_e g;
    unique case (k)
      4'd2:  g = G_ART;
      4'd3:  g = G_VEN;
      4'd4:  g = G_FILT;
      4'd12: g = G_WAIT;
      4'd0, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: g = G_STOP;
      default: g = G_NONE;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/aqpe_ctrl.sv =====
// Sequencing controller: scan, service, announce update and result transfer.
module aqpe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aqpe_pkg::status_t status_i,
  output aqpe_pkg::cmd_t    cmd_o
);
  import aqpe_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.hit) begin
          state_d = S_SERVICE;
        end else if (status_i.busy || status_i.last) begin
          state_d = S_SEQ;
        end
      end
      S_SERVICE: state_d = S_SEQ;
      S_SEQ:     state_d = S_EMIT;
      S_EMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.step = !status_i.hit && !status_i.busy && !status_i.last;
      end
      S_SERVICE: cmd_o.service  = 1'b1;
      S_SEQ:     cmd_o.announce = 1'b1;
      S_EMIT:    cmd_o.emit     = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/aqpe_datapath.sv =====
// Alarm state, qualify timers, guard flags, announce phase and output register.
module aqpe_datapath #(
  parameter int unsigned NumAlarms = aqpe_pkg::NUM_ALARMS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_step_we_i,
  input  logic [aqpe_pkg::STEP_W-1:0]   tick_step_i,
  input  logic [aqpe_pkg::COND_W-1:0]   condition_bits_i,
  input  aqpe_pkg::cmd_t                cmd_i,
  output aqpe_pkg::status_t             status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aqpe_pkg::IDX_W-1:0]    current_alarm_o,
  output logic [aqpe_pkg::COND_W-1:0]   active_mask_o,
  output logic                          guard_any_alarm_o,
  output logic                          guard_stop_actuators_o,
  output logic                          guard_art_air_o,
  output logic                          guard_ven_air_o,
  output logic                          guard_filter_air_o,
  output logic                          guard_wait_confirm_o,
  output logic                          announce_on_o,
  output logic                          announce_off_o,
  output logic [aqpe_pkg::IDX_W-1:0]    announced_alarm_o
);
  import aqpe_pkg::*;

  localparam logic [IDX_W-1:0] NoneCur = IDX_W'(NumAlarms);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NumAlarms - 1);

  logic [STEP_W-1:0]    step_q;
  logic [NumAlarms-1:0] flags_q, flags_d;
  logic [COND_W-1:0]    raised_q, raised_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     start_q, start_d;
  logic [IDX_W-1:0]     found_q, found_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  phase_e               phase_q, phase_d;
  logic [TIMER_W-1:0]   entry_q, entry_d;
  logic [TIMER_W-1:0]   exit_q, exit_d;
  logic [GUARD_W-1:0]   guard_q, guard_d;
  logic                 pon_q, pon_d;
  logic                 poff_q, poff_d;
  logic                 ovalid_q, ovalid_d;

  logic [SLOTS-1:0]     flags_ext;
  logic [SLOTS-1:0]     raised_ext;
  logic                 phys;
  logic                 act;
  logic                 found_act;
  logic [TIMER_W-1:0]   entry_sum;
  logic [TIMER_W-1:0]   exit_sum;
  guard_e               act_g;

  // Pad the per-alarm vectors to the full index space; slots beyond read zero.
  for (genvar j = 0; j < SLOTS; j++) begin : g_pad
    if (j < NumAlarms) begin : g_fl
      assign flags_ext[j] = flags_q[j];
    end else begin : g_fz
      assign flags_ext[j] = 1'b0;
    end
    if (j < COND_W) begin : g_rb
      assign raised_ext[j] = raised_q[j];
    end else begin : g_rz
      assign raised_ext[j] = 1'b0;
    end
  end

  assign phys      = raised_ext[idx_q];
  assign act       = flags_ext[idx_q];
  assign found_act = flags_ext[found_q];
  assign entry_sum = entry_q + TIMER_W'(step_q);
  assign exit_sum  = exit_q + TIMER_W'(step_q);
  assign act_g     = action_of(idx_q);

  assign status_o.hit      = phys ^ act;
  assign status_o.last     = (idx_q == LastIdx);
  assign status_o.busy     = (phase_q != PH_IDLE);
  assign status_o.out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    flags_d  = flags_q;
    raised_d = raised_q;
    idx_d    = idx_q;
    start_d  = start_q;
    found_d  = found_q;
    cur_d    = cur_q;
    phase_d  = phase_q;
    entry_d  = entry_q;
    exit_d   = exit_q;
    guard_d  = guard_q;
    pon_d    = pon_q;
    poff_d   = poff_q;

    if (cmd_i.load) begin
      raised_d = condition_bits_i;
      idx_d    = start_q;
    end

    if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
    end

    if (cmd_i.service) begin
      entry_d = entry_sum;
      exit_d  = exit_sum;
      if (!act) begin
        // newly raised entry becomes the scan anchor
        start_d = idx_q;
        found_d = idx_q;
        if (entry_sum > entry_ms(idx_q)) begin
          entry_d = '0;
          exit_d  = '0;
          for (int j = 0; j < NumAlarms; j++) begin
            if (idx_q == IDX_W'(j)) flags_d[j] = 1'b1;
          end
          cur_d          = idx_q;
          guard_d[G_ANY] = (idx_q != SIGNAL_ONLY);
          if (act_g != G_NONE) guard_d[act_g] = 1'b1;
        end
      end else if (exit_sum > exit_ms(idx_q)) begin
        entry_d = '0;
        exit_d  = '0;
        for (int j = 0; j < NumAlarms; j++) begin
          if (idx_q == IDX_W'(j)) flags_d[j] = 1'b0;
        end
        cur_d          = NoneCur;
        guard_d[G_ANY] = 1'b0;
        if (act_g != G_NONE) guard_d[act_g] = 1'b0;
        start_d        = '0;
      end
    end

    if (cmd_i.announce) begin
      pon_d  = 1'b0;
      poff_d = 1'b0;
      case (phase_q)
        PH_IDLE: begin
          if (start_q < NoneCur) begin
            if (found_act) begin
              phase_d = PH_ON;
            end else begin
              start_d = '0;
            end
          end
        end
        PH_ON: begin
          pon_d   = 1'b1;
          phase_d = PH_WAIT;
        end
        PH_WAIT: begin
          if (!found_act) begin
            phase_d = PH_IDLE;
            poff_d  = 1'b1;
            start_d = '0;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RESET;
      flags_q  <= '0;
      raised_q <= '0;
      idx_q    <= '0;
      start_q  <= '0;
      found_q  <= IDX_NONE;
      cur_q    <= NoneCur;
      phase_q  <= PH_IDLE;
      entry_q  <= '0;
      exit_q   <= '0;
      guard_q  <= '0;
      pon_q    <= 1'b0;
      poff_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (tick_step_we_i) step_q <= tick_step_i;
      flags_q  <= flags_d;
      raised_q <= raised_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      found_q  <= found_d;
      cur_q    <= cur_d;
      phase_q  <= phase_d;
      entry_q  <= entry_d;
      exit_q   <= exit_d;
      guard_q  <= guard_d;
      pon_q    <= pon_d;
      poff_q   <= poff_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Result register; payload held while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      current_alarm_o        <= cur_q;
      active_mask_o          <= flags_ext[COND_W-1:0];
      guard_any_alarm_o      <= guard_q[G_ANY];
      guard_stop_actuators_o <= guard_q[G_STOP];
      guard_art_air_o        <= guard_q[G_ART];
      guard_ven_air_o        <= guard_q[G_VEN];
      guard_filter_air_o     <= guard_q[G_FILT];
      guard_wait_confirm_o   <= guard_q[G_WAIT];
      announce_on_o          <= pon_q;
      announce_off_o         <= poff_q;
      announced_alarm_o      <= (pon_q || poff_q || phase_q != PH_IDLE) ? found_q : IDX_NONE;
    end
  end

  assign out_valid_o = ovalid_q;

`include "alarm_qualify_priority_engine_top_assert.svh"

  `AQPE_ASSERT_NXT(a_flags_only_on_service, !cmd_i.service, $stable(flags_q), "flags moved outside service")
  `AQPE_ASSERT_IMP(a_current_is_active, cur_q != NoneCur, flags_ext[cur_q], "current alarm not active")
  `AQPE_ASSERT_IMP(a_start_in_range, 1'b1, start_q < NoneCur, "scan start out of range")
  `AQPE_ASSERT_IMP(a_single_pulse, ovalid_q, !(announce_on_o && announce_off_o), "both pulses set")

endmodule

// ===== rtl/core/alarm_qualify_priority_engine_top.sv =====
// Alarm qualify and priority engine: one tick in, one status result out.
// Each tick is accepted while idle and scanned one alarm table entry per cycle
// from the saved start index until the first entry to service, the last table
// entry, or (when an announce is in progress) the first entry. A serviced entry
// then gets its timer update, followed by the announce update and the result load,
// which waits while out_stall_i holds the result register; in_stall_o stays high
// until the result is loaded. The user must write tick_step through tick_step_we_i
// only while idle; the block itself does not enforce this.
module alarm_qualify_priority_engine_top #(
  parameter int unsigned NumAlarms = aqpe_pkg::NUM_ALARMS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_step_we_i,
  input  logic [aqpe_pkg::STEP_W-1:0]   tick_step_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [aqpe_pkg::COND_W-1:0]   condition_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aqpe_pkg::IDX_W-1:0]    current_alarm_o,
  output logic [aqpe_pkg::COND_W-1:0]   active_mask_o,
  output logic                          guard_any_alarm_o,
  output logic                          guard_stop_actuators_o,
  output logic                          guard_art_air_o,
  output logic                          guard_ven_air_o,
  output logic                          guard_filter_air_o,
  output logic                          guard_wait_confirm_o,
  output logic                          announce_on_o,
  output logic                          announce_off_o,
  output logic [aqpe_pkg::IDX_W-1:0]    announced_alarm_o
);
  import aqpe_pkg::*;

  cmd_t    cmd;
  status_t status;

  aqpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aqpe_datapath #(
    .NumAlarms (NumAlarms)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .tick_step_we_i         (tick_step_we_i),
    .tick_step_i            (tick_step_i),
    .condition_bits_i       (condition_bits_i),
    .cmd_i                  (cmd),
    .status_o               (status),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .current_alarm_o        (current_alarm_o),
    .active_mask_o          (active_mask_o),
    .guard_any_alarm_o      (guard_any_alarm_o),
    .guard_stop_actuators_o (guard_stop_actuators_o),
    .guard_art_air_o        (guard_art_air_o),
    .guard_ven_air_o        (guard_ven_air_o),
    .guard_filter_air_o     (guard_filter_air_o),
    .guard_wait_confirm_o   (guard_wait_confirm_o),
    .announce_on_o          (announce_on_o),
    .announce_off_o         (announce_off_o),
    .announced_alarm_o      (announced_alarm_o)
  );

endmodule
